@@ rtl/dmlf_pkg.sv @@
// Shared constants, types and state encodings of the distance median low-pass filter.
package dmlf_pkg;

  localparam int WinSize = 5;
  localparam int WinIdxW = (WinSize > 1) ? $clog2(WinSize) : 1;
  localparam int WinCntW = $clog2(WinSize + 1);

  localparam int MmW     = 16;
  localparam int StW     = 3;
  localparam int RejW    = 8;
  localparam int AccW    = 2 * MmW;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 16;

  localparam logic [StW-1:0] StatusOk = 3'd0;

  localparam logic [CfgIdxW-1:0] CfgNearLimit = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgJumpGate  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgJumpLimit = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgNearNum   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgNearDen   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgFarNum    = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgFarDen    = 3'd6;

  typedef enum logic [1:0] {
    WIN_IDLE,
    WIN_LOADI,
    WIN_CAPI,
    WIN_SWEEP
  } win_state_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEDIAN,
    ST_SELECT,
    ST_MUL1,
    ST_MUL2,
    ST_DIVGO,
    ST_DIVWAIT,
    ST_EMIT
  } dmlf_state_e;

  typedef struct packed {
    logic           push;
    logic [MmW-1:0] sample;
  } win_req_t;

  typedef struct packed {
    logic           done;
    logic [MmW-1:0] median;
  } win_rsp_t;

  typedef struct packed {
    logic            start;
    logic [AccW-1:0] dividend;
    logic [MmW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [MmW-1:0] quotient;
  } div_rsp_t;

endpackage

@@ rtl/dmlf_window.sv @@
// Ring window of good samples with a serial rank-select median engine.
module dmlf_window import dmlf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  win_req_t req_i,
  output win_rsp_t rsp_o
);

  logic [MmW-1:0]     mem_q [WinSize];
  win_state_e         state_q, state_d;
  logic [WinIdxW-1:0] wp_q, wp_d;
  logic [WinCntW-1:0] fill_q, fill_d;
  logic [WinIdxW-1:0] i_q, i_d;
  logic [WinCntW-1:0] j_q, j_d;
  logic [WinCntW-1:0] rank_q, rank_d, rank_sum;
  logic [WinIdxW-1:0] cj_q;
  logic               cmp_v_q, cmp_v_d;
  logic [MmW-1:0]     rd_q, cand_q, med_q;
  logic               done_q;
  logic [WinIdxW-1:0] rd_addr;
  logic               less, last_cmp, match;

  // Stable rank: ties are broken by window position.
  assign less     = (rd_q < cand_q) || ((rd_q == cand_q) && (cj_q < i_q));
  assign rank_sum = rank_q + WinCntW'(less);
  assign last_cmp = cmp_v_q && ((WinCntW'(cj_q) + WinCntW'(1)) == fill_q);
  assign match    = last_cmp && (rank_sum == (fill_q >> 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      WIN_IDLE:  if (req_i.push) state_d = WIN_LOADI;
      WIN_LOADI: state_d = WIN_CAPI;
      WIN_CAPI:  state_d = WIN_SWEEP;
      WIN_SWEEP: if (last_cmp) state_d = match ? WIN_IDLE : WIN_LOADI;
      default:   state_d = WIN_IDLE;
    endcase
  end

  always_comb begin
    rd_addr = (state_q == WIN_SWEEP) ? j_q[WinIdxW-1:0] : i_q;
  end

  always_comb begin
    wp_d    = wp_q;
    fill_d  = fill_q;
    i_d     = i_q;
    j_d     = j_q;
    rank_d  = rank_q;
    cmp_v_d = (state_q == WIN_SWEEP) && (j_q < fill_q);
    if (req_i.push) begin
      wp_d = (wp_q == WinIdxW'(WinSize - 1)) ? '0 : wp_q + WinIdxW'(1);
      if (fill_q < WinCntW'(WinSize)) fill_d = fill_q + WinCntW'(1);
      i_d = '0;
    end
    if (state_q == WIN_CAPI) begin
      j_d    = '0;
      rank_d = '0;
    end
    if (state_q == WIN_SWEEP) begin
      if (j_q < fill_q) j_d = j_q + WinCntW'(1);
      if (cmp_v_q) rank_d = rank_sum;
      if (last_cmp && !match) i_d = i_q + WinIdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= WIN_IDLE;
      wp_q    <= '0;
      fill_q  <= '0;
      i_q     <= '0;
      j_q     <= '0;
      rank_q  <= '0;
      cmp_v_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      fill_q  <= fill_d;
      i_q     <= i_d;
      j_q     <= j_d;
      rank_q  <= rank_d;
      cmp_v_q <= cmp_v_d;
      done_q  <= match;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.push) mem_q[wp_q] <= req_i.sample;
    rd_q <= mem_q[rd_addr];
    cj_q <= j_q[WinIdxW-1:0];
    if (state_q == WIN_CAPI) cand_q <= rd_q;
    if (match) med_q <= cand_q;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.median = med_q;

endmodule

@@ rtl/dmlf_div.sv @@
// Serial restoring divider, one quotient bit per cycle, quotient known to fit 16 bits.
module dmlf_div import dmlf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CntW = $clog2(MmW);

  logic [MmW-1:0]  rem_q, quo_q, den_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [MmW:0]    trial;
  logic            qbit;

  assign trial = {rem_q, quo_q[MmW-1]};
  assign qbit  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(MmW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.dividend[AccW-1:MmW];
      quo_q <= req_i.dividend[MmW-1:0];
      den_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= qbit ? MmW'(trial - {1'b0, den_q}) : trial[MmW-1:0];
      quo_q <= {quo_q[MmW-2:0], qbit};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

@@ rtl/distance_median_lowpass_filter.sv @@
// Top level: sequencer, jump gate, shared multiply-accumulate and output register.
//
// Channel  Dir  Fields (lowest bit up)                      Transaction when
// s_axis   in   tdata: sample_mm[15:0]; tuser: sample_status  tvalid & tready
// m_axis   out  tdata: filtered_mm, raw_echo_mm; tuser: status tvalid & tready
// cfg      in   cfg_idx_i selects register, cfg_wdata_i data   cfg_we_i high
//
// A bad sample goes from the idle step straight to the emit step, which loads
// the output register. A good sample passes the median engine, then the gate,
// select, two multiply-accumulate steps and the 16-step divider; the first
// good sample and a bypassed select go straight to the emit step instead.
// The median's single compare port and the serial divider dominate this path.
// Reset clears all control state and loads the register defaults. A stalled
// output holds the sequencer in its emit step; input is taken only when idle.
module distance_median_lowpass_filter import dmlf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [MmW-1:0]     s_axis_tdata,   // sample_mm
  input  logic [StW-1:0]     s_axis_tuser,   // sample_status
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [2*MmW-1:0]   m_axis_tdata,   // filtered_mm, raw_echo_mm
  output logic [StW-1:0]     m_axis_tuser,   // result_status
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  dmlf_state_e state_q, state_d;

  // Configuration registers
  logic [MmW-1:0]  near_q, gate_q, nnum_q, nden_q, fnum_q, fden_q;
  logic [RejW-1:0] lim_q;

  // Filter state
  logic [MmW-1:0]  last_q;
  logic            have_q;
  logic [RejW-1:0] rej_q;

  // Per-transaction working registers
  logic [MmW-1:0]  sample_q, cand_q, num_q, den_q, dn_q, res_mm_q;
  logic [StW-1:0]  res_st_q;
  logic [AccW-1:0] acc_q;

  // Output register
  logic            out_valid_q;
  logic [MmW-1:0]  out_mm_q, out_raw_q;
  logic [StW-1:0]  out_st_q;

  win_req_t win_req;
  win_rsp_t win_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic            in_acc, in_good, out_free;
  logic [MmW:0]    gate_sum;
  logic [MmW-1:0]  gate_sat;
  logic            near_prev, jump, hold_jump, use_near, bypass;
  logic [MmW-1:0]  sel_num, sel_den, mul_a, mul_b;
  logic [AccW-1:0] product, addend, mac;

  dmlf_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (win_req),
    .rsp_o  (win_rsp)
  );

  dmlf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_good  = (s_axis_tuser == StatusOk);
  assign out_free = !out_valid_q || m_axis_tready;

  // Jump gate: saturate the sum, then test the fresh median against it while the previous output is near.
  assign gate_sum  = {1'b0, last_q} + {1'b0, gate_q};
  assign gate_sat  = gate_sum[MmW] ? '1 : gate_sum[MmW-1:0];
  assign near_prev = (last_q < near_q);
  assign jump      = near_prev && (win_rsp.median > gate_sat);
  assign hold_jump = jump && (rej_q < lim_q);

  // Coefficient select and bypass test.
  assign use_near = (cand_q < near_q) || near_prev;
  assign sel_num  = use_near ? nnum_q : fnum_q;
  assign sel_den  = use_near ? nden_q : fden_q;
  assign bypass   = (sel_den == '0) || (sel_num >= sel_den);

  // Shared multiply-accumulate: num*cand + den/2, then + (den-num)*prev.
  assign mul_a   = (state_q == ST_MUL1) ? num_q  : dn_q;
  assign mul_b   = (state_q == ST_MUL1) ? cand_q : last_q;
  assign product = AccW'(mul_a) * AccW'(mul_b);
  assign addend  = (state_q == ST_MUL1) ? AccW'(den_q >> 1) : acc_q;
  assign mac     = product + addend;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_acc) state_d = in_good ? ST_MEDIAN : ST_EMIT;
      ST_MEDIAN:  if (win_rsp.done) state_d = have_q ? ST_SELECT : ST_EMIT;
      ST_SELECT:  state_d = bypass ? ST_EMIT : ST_MUL1;
      ST_MUL1:    state_d = ST_MUL2;
      ST_MUL2:    state_d = ST_DIVGO;
      ST_DIVGO:   state_d = ST_DIVWAIT;
      ST_DIVWAIT: if (div_rsp.done) state_d = ST_EMIT;
      ST_EMIT:    if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready    = (state_q == ST_IDLE);
    win_req.push     = in_acc && in_good;
    win_req.sample   = s_axis_tdata;
    div_req.start    = (state_q == ST_DIVGO);
    div_req.dividend = acc_q;
    div_req.divisor  = den_q;
  end

  // Configuration writes; an unknown index is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q <= MmW'(300);
      gate_q <= MmW'(100);
      lim_q  <= RejW'(3);
      nnum_q <= MmW'(1);
      nden_q <= MmW'(4);
      fnum_q <= MmW'(1);
      fden_q <= MmW'(2);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgNearLimit: near_q <= cfg_wdata_i;
        CfgJumpGate:  gate_q <= cfg_wdata_i;
        CfgJumpLimit: lim_q  <= cfg_wdata_i[RejW-1:0];
        CfgNearNum:   nnum_q <= cfg_wdata_i;
        CfgNearDen:   nden_q <= cfg_wdata_i;
        CfgFarNum:    fnum_q <= cfg_wdata_i;
        CfgFarDen:    fden_q <= cfg_wdata_i;
        default:      ;
      endcase
    end
  end

  // Control state: sequencer, filter state, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= '0;
      have_q      <= 1'b0;
      rej_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_MEDIAN) && win_rsp.done) begin
        if (have_q) begin
          // Hold a suspect jump, or let it pass once the limit is reached.
          rej_q <= hold_jump ? rej_q + RejW'(1) : '0;
        end else begin
          last_q <= win_rsp.median;
          have_q <= 1'b1;
        end
      end
      if ((state_q == ST_SELECT) && bypass) last_q <= cand_q;
      if ((state_q == ST_DIVWAIT) && div_rsp.done) last_q <= div_rsp.quotient;
      if ((state_q == ST_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          sample_q <= s_axis_tdata;
          if (in_good) begin
            res_st_q <= StatusOk;
          end else begin
            res_mm_q <= have_q ? last_q : '0;
            res_st_q <= have_q ? StatusOk : s_axis_tuser;
          end
        end
      end
      ST_MEDIAN: begin
        if (win_rsp.done) begin
          cand_q   <= hold_jump && have_q ? last_q : win_rsp.median;
          res_mm_q <= win_rsp.median;
        end
      end
      ST_SELECT: begin
        num_q    <= sel_num;
        den_q    <= sel_den;
        dn_q     <= sel_den - sel_num;
        res_mm_q <= cand_q;
      end
      ST_MUL1, ST_MUL2: acc_q <= mac;
      ST_DIVWAIT: if (div_rsp.done) res_mm_q <= div_rsp.quotient;
      ST_EMIT: begin
        if (out_free) begin
          out_mm_q  <= res_mm_q;
          out_raw_q <= sample_q;
          out_st_q  <= res_st_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_raw_q, out_mm_q};
  assign m_axis_tuser  = out_st_q;

  a_win_done_in_median: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_rsp.done |-> (state_q == ST_MEDIAN))
    else $error("median result outside the median step");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIVWAIT))
    else $error("divider result outside the divide wait step");

  a_select_has_prev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SELECT) |-> have_q)
    else $error("low-pass select without a previous output");

  a_quotient_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVWAIT) |-> (acc_q[AccW-1:MmW] < den_q))
    else $error("low-pass quotient would overflow 16 bits");

  a_have_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(have_q))
    else $error("output-present flag cleared outside reset");

endmodule
